FILE: rtl/homogeneous_vertex_transform_unit_defines.svh
// ============================================================================
// Homogeneous vertex transform unit: assertion macros
// Shared assertion macros for the transform unit. They compile to nothing
// when SYNTHESIS is defined.
// ============================================================================
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define HVT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hvt check failed");
`define HVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hvt check failed");
`else
`define HVT_ASSERT_SAME(lbl, ante, cons)
`define HVT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/hvt_pkg.sv
// ============================================================================
// Homogeneous vertex transform unit: package
// Operation codes, sequencer state types and fixed widths.
// ============================================================================
package hvt_pkg;

    localparam int DATA_W      = 32;
    localparam int PROD_W      = 64;
    localparam int ACC_W       = 66;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 96;
    localparam int USER_OUT_W  = 2;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPOSE = 2'd1,
        OP_XFORM   = 2'd2,
        OP_IDENT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIN
    } dstate_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quo;
        logic                     sat;
    } div_res_t;

endpackage

FILE: rtl/hvt_div.sv
// ============================================================================
// Homogeneous vertex transform unit: perspective divider
// Restoring divider, one quotient bit per cycle, that forms
// (num << FRAC_BITS) / den truncated toward zero and saturated to 32 bits.
// ============================================================================
module hvt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  num,
    input  logic signed [31:0]  den,
    output logic                done,
    output hvt_pkg::div_res_t   res
);
    import hvt_pkg::*;

    localparam int NW    = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    dstate_t              state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [NW-1:0]        dvd_reg;
    logic [NW-1:0]        quo_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    dmag_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    logic                 nonneg_reg;

    logic [DATA_W-1:0]    num_mag;
    logic [DATA_W-1:0]    den_mag;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;
    logic                 ge;
    logic                 pos_ovf;
    logic                 neg_ovf;

    assign num_mag = num[31] ? DATA_W'(-num) : num;
    assign den_mag = den[31] ? DATA_W'(-den) : den;
    assign trial   = {rem_reg, dvd_reg[NW-1]};
    assign diff    = trial - {1'b0, dmag_reg};
    assign ge      = (trial >= {1'b0, dmag_reg});
    assign pos_ovf = |quo_reg[NW-1:31];
    assign neg_ovf = (|quo_reg[NW-1:32]) || (quo_reg[31] && (|quo_reg[30:0]));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = (den == 32'sd0) ? DV_FIN : DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = DV_FIN;
                end
            end
            DV_FIN:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done    = (state_reg == DV_FIN);
        res.sat = 1'b0;
        res.quo = quo_reg[DATA_W-1:0];
        priority if (zero_reg)
        begin
            res.sat = 1'b1;
            res.quo = nonneg_reg ? S32_MAX : S32_MIN;
        end
        else if (neg_reg)
        begin
            res.sat = neg_ovf;
            res.quo = neg_ovf ? S32_MIN : DATA_W'(-quo_reg[DATA_W-1:0]);
        end
        else
        begin
            res.sat = pos_ovf;
            res.quo = pos_ovf ? S32_MAX : quo_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            dvd_reg    <= {num_mag, {FRAC_BITS{1'b0}}};
            quo_reg    <= '0;
            rem_reg    <= '0;
            dmag_reg   <= den_mag;
            cnt_reg    <= CNT_W'(NW);
            neg_reg    <= num[31] ^ den[31];
            zero_reg   <= (den == 32'sd0);
            nonneg_reg <= !num[31];
        end
        else if (state_reg == DV_RUN)
        begin
            dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

FILE: rtl/homogeneous_vertex_transform_unit.sv
// ============================================================================
// Homogeneous vertex transform unit
// 4x4 fixed-point matrix stage with compose, point transform and perspective
// divide, built around one shared 32x32 multiplier and one serial divider.
// ============================================================================
// A load or identity beat finishes in the cycle it is accepted. A compose
// streams all 64 multiply-adds through the single multiplier, one per cycle.
// A transform issues 16 multiply-adds and then runs three divisions on the
// serial divider, which skips its bit loop and saturates when w is zero.
// The input is not ready while an operation is in progress. A finished
// result waits in the output register while further beats are accepted.
`include "homogeneous_vertex_transform_unit_defines.svh"

module homogeneous_vertex_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row_index[1:0], col_index[3:2], element_value[35:4], point_x[67:36],
    // point_y[99:68], point_z[131:100], zero fill[135:132]
    input  logic [hvt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [hvt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // w_zero[0], overflowed[1]
    output logic [hvt_pkg::USER_OUT_W-1:0]      m_axis_tuser
);
    import hvt_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0]  HALF = ACC_W'(1) << (FRAC_BITS - 1);

    state_t                     state_reg, state_next;

    logic signed [DATA_W-1:0]   cur_reg [16];
    logic signed [DATA_W-1:0]   stg_reg [16];
    logic signed [DATA_W-1:0]   pnt_reg [3];
    logic signed [DATA_W-1:0]   hom_reg [4];
    logic signed [DATA_W-1:0]   row_reg [3];
    logic signed [DATA_W-1:0]   quo_reg [3];
    logic                       xform_reg;
    logic                       ovf_reg;

    logic [1:0]                 i_reg, j_reg, k_reg;
    logic                       issue_reg;

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       p_vld_reg, p_first_reg, p_last_reg, p_end_reg;
    logic [1:0]                 p_row_reg, p_col_reg;

    logic signed [ACC_W-1:0]    acc_reg;
    logic                       a_vld_reg, a_end_reg;
    logic [1:0]                 a_row_reg, a_col_reg;

    logic [1:0]                 dv_idx_reg;
    logic                       dv_go_reg;
    logic                       dv_done;
    div_res_t                   dv_res;

    logic                       out_vld_reg;
    logic [OUT_TDATA_W-1:0]     out_data_reg;
    logic [USER_OUT_W-1:0]      out_user_reg;

    logic                       accept;
    op_t                        op;
    logic                       issue_last;
    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [ACC_W-1:0]    shf;
    logic [ACC_W-32:0]          shf_hi;
    logic                       res_fits;
    logic signed [DATA_W-1:0]   res_val;
    logic                       mac_done;
    logic                       out_load;
    logic                       out_free;

    assign op     = op_t'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign issue_last = (k_reg == 2'd3) && (i_reg == 2'd3) && (xform_reg || j_reg == 2'd3);
    assign mul_a      = cur_reg[{i_reg, k_reg}];
    assign mul_b      = xform_reg ? ((k_reg == 2'd3) ? ONE : pnt_reg[k_reg])
                                  : stg_reg[{k_reg, j_reg}];

    assign rnd      = acc_reg + HALF;
    assign shf      = rnd >>> FRAC_BITS;
    assign shf_hi   = shf[ACC_W-1:31];
    assign res_fits = (&shf_hi) || !(|shf_hi);
    assign res_val  = res_fits ? shf[DATA_W-1:0] : (shf[ACC_W-1] ? S32_MIN : S32_MAX);
    assign mac_done = a_vld_reg && a_end_reg;
    assign out_free = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_COMPOSE || op == OP_XFORM))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = xform_reg ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (dv_done && dv_idx_reg == 2'd2)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        out_load      = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issue_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            a_vld_reg   <= 1'b0;
            dv_go_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int n = 0; n < 16; n++)
            begin
                cur_reg[n] <= (n % 5 == 0) ? ONE : '0;
                stg_reg[n] <= (n % 5 == 0) ? ONE : '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (accept && op == OP_LOAD)
            begin
                stg_reg[{s_axis_tdata[1:0], s_axis_tdata[3:2]}] <= s_axis_tdata[35:4];
            end

            if (accept && op == OP_IDENT)
            begin
                for (int n = 0; n < 16; n++)
                begin
                    cur_reg[n] <= (n % 5 == 0) ? ONE : '0;
                end
            end

            if (accept && (op == OP_COMPOSE || op == OP_XFORM))
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && issue_last)
            begin
                issue_reg <= 1'b0;
            end

            p_vld_reg <= issue_reg;
            a_vld_reg <= p_vld_reg && p_last_reg;

            if (a_vld_reg && !xform_reg && a_col_reg == 2'd3)
            begin
                cur_reg[{a_row_reg, 2'd0}] <= row_reg[0];
                cur_reg[{a_row_reg, 2'd1}] <= row_reg[1];
                cur_reg[{a_row_reg, 2'd2}] <= row_reg[2];
                cur_reg[{a_row_reg, 2'd3}] <= res_val;
            end

            dv_go_reg <= (state_reg == ST_MAC && mac_done && xform_reg)
                      || (state_reg == ST_DIV && dv_done && dv_idx_reg != 2'd2);

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xform_reg  <= (op == OP_XFORM);
            pnt_reg[0] <= s_axis_tdata[67:36];
            pnt_reg[1] <= s_axis_tdata[99:68];
            pnt_reg[2] <= s_axis_tdata[131:100];
            ovf_reg    <= 1'b0;
            i_reg      <= 2'd0;
            j_reg      <= 2'd0;
            k_reg      <= 2'd0;
        end
        else if (issue_reg)
        begin
            k_reg <= k_reg + 2'd1;
            if (k_reg == 2'd3)
            begin
                if (xform_reg || j_reg == 2'd3)
                begin
                    j_reg <= 2'd0;
                    i_reg <= i_reg + 2'd1;
                end
                else
                begin
                    j_reg <= j_reg + 2'd1;
                end
            end
        end

        prod_reg    <= mul_a * mul_b;
        p_first_reg <= (k_reg == 2'd0);
        p_last_reg  <= (k_reg == 2'd3);
        p_end_reg   <= issue_last;
        p_row_reg   <= i_reg;
        p_col_reg   <= j_reg;

        if (p_vld_reg)
        begin
            acc_reg   <= (p_first_reg ? ACC_W'(0) : acc_reg)
                       + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            a_end_reg <= p_end_reg;
            a_row_reg <= p_row_reg;
            a_col_reg <= p_col_reg;
        end

        if (a_vld_reg)
        begin
            if (xform_reg)
            begin
                hom_reg[a_row_reg] <= res_val;
                if (!res_fits)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (a_col_reg != 2'd3)
            begin
                row_reg[a_col_reg] <= res_val;
            end
        end

        if (state_reg == ST_MAC)
        begin
            dv_idx_reg <= 2'd0;
        end
        else if (state_reg == ST_DIV && dv_done)
        begin
            quo_reg[dv_idx_reg] <= dv_res.quo;
            if (dv_res.sat)
            begin
                ovf_reg <= 1'b1;
            end
            dv_idx_reg <= dv_idx_reg + 2'd1;
        end

        if (out_load)
        begin
            out_data_reg <= {quo_reg[2], quo_reg[1], quo_reg[0]};
            out_user_reg <= {ovf_reg, (hom_reg[3] == 32'sd0)};
        end
    end

    hvt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_go_reg),
        .num   (hom_reg[dv_idx_reg]),
        .den   (hom_reg[3]),
        .done  (dv_done),
        .res   (dv_res)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `HVT_ASSERT_SAME(a_div_in_div_state, dv_done, state_reg == ST_DIV)
    `HVT_ASSERT_SAME(a_mac_only_in_mac, a_vld_reg || p_vld_reg, state_reg == ST_MAC)
    `HVT_ASSERT_NEXT(a_xform_starts_mac, accept && op == OP_XFORM, state_reg == ST_MAC && issue_reg)
    `HVT_ASSERT_NEXT(a_ident_loads, accept && op == OP_IDENT, cur_reg[0] == ONE && cur_reg[1] == 32'sd0)

endmodule
